>>> rtl/ecc_pkg.sv
// ----------------------------------------------------------------------------
// ecc_pkg: shared types and constants of the epoch calendar clock
// Command codes, sequencer states and calendar constants.
// ----------------------------------------------------------------------------
package ecc_pkg;

   localparam logic [1:0] CMD_TICK    = 2'd0;
   localparam logic [1:0] CMD_SET     = 2'd1;
   localparam logic [1:0] CMD_GET     = 2'd2;
   localparam logic [1:0] CMD_ELAPSED = 2'd3;

   localparam logic [31:0] SECS_LEAP_YEAR = 32'd31622400;
   localparam logic [31:0] SECS_YEAR      = 32'd31536000;
   localparam logic [31:0] SECS_DAY       = 32'd86400;
   localparam logic [31:0] SECS_HOUR      = 32'd3600;
   localparam logic [31:0] SECS_MINUTE    = 32'd60;
   localparam logic [11:0] YEAR_FIRST     = 12'd1970;
   localparam logic [11:0] YEAR_LAST      = 12'd2099;

   // reciprocals: (x >> 7) * DAY_RECIP >> 35 is x / 86400 for any 32-bit x,
   // x * HOUR_RECIP >> 29 is x / 3600 below 2^17, x * MINUTE_RECIP >> 18 is
   // x / 60 below 2^12
   localparam logic [50:0] DAY_RECIP    = 51'd50903317;
   localparam logic [34:0] HOUR_RECIP   = 35'd149131;
   localparam logic [24:0] MINUTE_RECIP = 25'd4370;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_YEAR_ENC,
      ST_MONTH_ENC,
      ST_DAY_ENC,
      ST_HOUR_ENC,
      ST_MIN_ENC,
      ST_TIME_ENC,
      ST_DAY_DEC,
      ST_DAY_REM,
      ST_YEAR_DEC,
      ST_MONTH_DEC,
      ST_HOUR_DEC,
      ST_HOUR_REM,
      ST_MIN_DEC,
      ST_MIN_REM,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic        ok;
      logic [11:0] out_year;
      logic [3:0]  out_month;
      logic [4:0]  out_day;
      logic [4:0]  out_hour;
      logic [5:0]  out_minute;
      logic [5:0]  out_second;
      logic [2:0]  weekday;
      logic [31:0] elapsed;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } req_type;

   function automatic logic is_leap(input logic [11:0] y);
      logic d100;
      logic d400;
      d100 = (y == 12'd1800) || (y == 12'd1900) || (y == 12'd2100) ||
             (y == 12'd2200) || (y == 12'd2300) || (y == 12'd2500) ||
             (y == 12'd2600) || (y == 12'd2700);
      d400 = (y == 12'd2000) || (y == 12'd2400) || (y == 12'd1600);
      return (y[1:0] == 2'b00) && (!d100 || d400);
   endfunction

   function automatic logic [4:0] month_days(input logic [3:0] m, input logic lp);
      logic [4:0] r;
      case (m)
         4'd1:    r = lp ? 5'd29 : 5'd28;
         4'd3, 4'd5, 4'd8, 4'd10: r = 5'd30;
         default: r = 5'd31;
      endcase
      return r;
   endfunction

   // reduce a value below 49 to its remainder modulo 7
   function automatic logic [2:0] mod7_small(input logic [5:0] v);
      logic [5:0] r;
      r = v;
      if (r >= 6'd28) r = r - 6'd28;
      if (r >= 6'd14) r = r - 6'd14;
      if (r >= 6'd7)  r = r - 6'd7;
      return r[2:0];
   endfunction

endpackage

>>> rtl/ecc_if.sv
// ----------------------------------------------------------------------------
// ecc_if: valid/ready stream interface
// Carries one payload of a generic packed type.
// ----------------------------------------------------------------------------
interface ecc_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> rtl/ecc_alu.sv
// ----------------------------------------------------------------------------
// ecc_alu: shared add/subtract and compare unit
// Computes a + b or a - b and flags a >= b on 32-bit operands.
// ----------------------------------------------------------------------------
module ecc_alu (
   input  logic        sub,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [31:0] y,
   output logic        ge
);
   logic [32:0] diff;
   assign diff = {1'b0, a} - {1'b0, b};
   assign ge   = !diff[32];
   assign y    = sub ? diff[31:0] : a + b;
endmodule

>>> rtl/ecc_seq.sv
// ----------------------------------------------------------------------------
// ecc_seq: conversion sequencer
// Steps through years, months and time units with the shared unit.
// ----------------------------------------------------------------------------
module ecc_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  ecc_pkg::req_type  req,
   input  logic              rsp_taken,
   output logic              busy,
   output logic              done,
   output ecc_pkg::rsp_type  rsp
);
   import ecc_pkg::*;

   state_type   state_ff, state_in;
   req_type     req_ff, req_in;
   logic [31:0] count_ff, count_in;
   logic [31:0] acc_ff, acc_in;
   logic [11:0] yr_ff, yr_in;
   logic [3:0]  mo_ff, mo_in;
   logic [4:0]  hr_ff, hr_in;
   logic [5:0]  mi_ff, mi_in;
   logic [19:0] days_ff, days_in;
   logic [2:0]  wd_ff, wd_in;
   rsp_type     rsp_ff, rsp_in;

   logic        alu_sub, alu_ge;
   logic [31:0] alu_a, alu_b, alu_y;
   logic        valid_date;
   logic [31:0] mlen;
   logic [50:0] day_prod;
   logic [34:0] hour_prod;
   logic [24:0] min_prod;

   ecc_alu u_alu (.sub(alu_sub), .a(alu_a), .b(alu_b), .y(alu_y), .ge(alu_ge));

   assign valid_date = (req.year >= YEAR_FIRST) && (req.year <= YEAR_LAST) &&
                       (req.month >= 4'd1) && (req.month <= 4'd12);

   assign day_prod  = {26'd0, acc_ff[31:7]} * DAY_RECIP;
   assign hour_prod = {18'd0, acc_ff[16:0]} * HOUR_RECIP;
   assign min_prod  = {13'd0, acc_ff[11:0]} * MINUTE_RECIP;

   always_comb begin
      mlen = {27'd0, month_days(mo_ff, is_leap(yr_ff))};
      if (state_ff == ST_MONTH_ENC) begin
         mlen = {27'd0, month_days(mo_ff, is_leap(req_ff.year))};
      end
   end

   always_comb begin
      alu_sub = 1'b0;
      alu_a   = acc_ff;
      alu_b   = 32'd0;
      unique case (state_ff)
         ST_YEAR_ENC:  alu_b = is_leap(yr_ff) ? SECS_LEAP_YEAR : SECS_YEAR;
         ST_MONTH_ENC: alu_b = mlen * SECS_DAY;
         ST_DAY_ENC:   alu_b = ({27'd0, req_ff.day} - 32'd1) * SECS_DAY;
         ST_HOUR_ENC:  alu_b = {27'd0, req_ff.hour} * SECS_HOUR;
         ST_MIN_ENC:
            alu_b = {26'd0, req_ff.minute} * SECS_MINUTE + {26'd0, req_ff.second};
         ST_TIME_ENC: begin alu_sub = 1'b1; alu_a = count_ff; alu_b = acc_ff; end
         ST_DAY_REM:  begin alu_sub = 1'b1; alu_b = {12'd0, days_ff} * SECS_DAY; end
         ST_YEAR_DEC: begin
            alu_sub = 1'b1;
            alu_a = {12'd0, days_ff};
            alu_b = is_leap(yr_ff) ? 32'd366 : 32'd365;
         end
         ST_MONTH_DEC: begin alu_sub = 1'b1; alu_a = {12'd0, days_ff}; alu_b = mlen; end
         ST_HOUR_REM:  begin alu_sub = 1'b1; alu_b = {27'd0, hr_ff} * SECS_HOUR; end
         ST_MIN_REM:   begin alu_sub = 1'b1; alu_b = {26'd0, mi_ff} * SECS_MINUTE; end
         default: ;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (start) begin
            if (req.cmd == CMD_GET) state_in = ST_DAY_DEC;
            else if (req.cmd != CMD_TICK && valid_date) state_in = ST_YEAR_ENC;
            else if (req.cmd != CMD_TICK) state_in = ST_DONE;
         end
         ST_YEAR_ENC:  if (yr_ff == req_ff.year) state_in = ST_MONTH_ENC;
         ST_MONTH_ENC: if (mo_ff + 4'd1 == req_ff.month) state_in = ST_DAY_ENC;
         ST_DAY_ENC:   state_in = ST_HOUR_ENC;
         ST_HOUR_ENC:  state_in = ST_MIN_ENC;
         ST_MIN_ENC:   state_in = ST_TIME_ENC;
         ST_TIME_ENC:  state_in = ST_DONE;
         ST_DAY_DEC:   state_in = ST_DAY_REM;
         ST_DAY_REM:   state_in = ST_YEAR_DEC;
         ST_YEAR_DEC:  if (!alu_ge) state_in = ST_MONTH_DEC;
         ST_MONTH_DEC: if (!alu_ge || mo_ff == 4'd11) state_in = ST_HOUR_DEC;
         ST_HOUR_DEC:  state_in = ST_HOUR_REM;
         ST_HOUR_REM:  state_in = ST_MIN_DEC;
         ST_MIN_DEC:   state_in = ST_MIN_REM;
         ST_MIN_REM:   state_in = ST_DONE;
         ST_DONE:      if (rsp_taken) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_in = req_ff; count_in = count_ff; acc_in = acc_ff; yr_in = yr_ff;
      mo_in = mo_ff; hr_in = hr_ff; mi_in = mi_ff; days_in = days_ff;
      wd_in = wd_ff; rsp_in = rsp_ff;
      unique case (state_ff)
         ST_IDLE: if (start) begin
            req_in = req; acc_in = 32'd0; yr_in = YEAR_FIRST; mo_in = 4'd0;
            hr_in = 5'd0; mi_in = 6'd0; days_in = 20'd0; rsp_in = '0;
            wd_in = 3'd4;
            if (req.cmd == CMD_TICK) count_in = count_ff + 32'd1;
            if (req.cmd == CMD_GET) acc_in = count_ff;
         end
         ST_YEAR_ENC: if (yr_ff != req_ff.year) begin
            acc_in = alu_y; yr_in = yr_ff + 12'd1;
         end
         ST_MONTH_ENC: if (mo_ff + 4'd1 != req_ff.month) begin
            acc_in = alu_y; mo_in = mo_ff + 4'd1;
         end
         ST_DAY_ENC, ST_HOUR_ENC, ST_MIN_ENC: acc_in = alu_y;
         ST_TIME_ENC: begin
            rsp_in.ok = 1'b1;
            if (req_ff.cmd == CMD_ELAPSED) rsp_in.elapsed = alu_y;
            else count_in = acc_ff;
         end
         ST_DAY_DEC: days_in = {4'd0, day_prod[50:35]};
         ST_DAY_REM: acc_in = alu_y;
         ST_YEAR_DEC: if (alu_ge) begin
            days_in = alu_y[19:0]; yr_in = yr_ff + 12'd1;
            wd_in = mod7_small({3'd0, wd_ff} + (is_leap(yr_ff) ? 6'd2 : 6'd1));
         end
         ST_MONTH_DEC: if (alu_ge && mo_ff != 4'd11) begin
            days_in = alu_y[19:0]; mo_in = mo_ff + 4'd1;
            wd_in = mod7_small({3'd0, wd_ff} + {1'b0, mlen[4:0]});
         end
         ST_HOUR_DEC: hr_in = hour_prod[33:29];
         ST_HOUR_REM: acc_in = alu_y;
         ST_MIN_DEC:  mi_in = min_prod[23:18];
         ST_MIN_REM: begin
            rsp_in.ok = 1'b1; rsp_in.out_year = yr_ff; rsp_in.out_month = mo_ff + 4'd1;
            rsp_in.out_day = days_ff[4:0] + 5'd1; rsp_in.out_hour = hr_ff;
            rsp_in.out_minute = mi_ff; rsp_in.out_second = alu_y[5:0];
            rsp_in.weekday = mod7_small({3'd0, wd_ff} + {1'b0, days_ff[4:0]});
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= 32'd0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      req_ff <= req_in; acc_ff <= acc_in; yr_ff <= yr_in; mo_ff <= mo_in;
      hr_ff <= hr_in; mi_ff <= mi_in; days_ff <= days_in; wd_ff <= wd_in;
      rsp_ff <= rsp_in;
   end

   assign busy = state_ff != ST_IDLE;
   assign done = state_ff == ST_DONE;
   assign rsp  = rsp_ff;
endmodule

>>> rtl/epoch_calendar_clock.sv
// ----------------------------------------------------------------------------
// epoch_calendar_clock: seconds counter with calendar conversion
// Top level; couples the request and response channels to the sequencer.
// ----------------------------------------------------------------------------
// Usage: req carries a command and a date; rsp returns one transaction for
// set, get and elapsed, none for tick. A tick is applied at its accepting
// edge and the next transaction can follow at the next edge.
// Set and elapsed walk one year per cycle from 1970 and one month per cycle
// in the shared unit, then add the day, hour and minute terms; an invalid
// date goes straight to the response.
// Get splits the counter into days and seconds by reciprocal multiplication,
// walks years (up to 2106) and months one per cycle, then splits hours and
// minutes.
// One transaction is in flight at a time: the block is ready only when idle,
// so the next request is accepted only after the response has been taken
// and the sequencer has returned to idle.
// Reset clears the counter to 1970-01-01 00:00:00 and idles the sequencer.
// A stalled receiver holds the response and the block stays not ready.
// ----------------------------------------------------------------------------
module epoch_calendar_clock (
   input logic clock,
   input logic reset,
   ecc_if.sink   req,
   ecc_if.source rsp
);
   import ecc_pkg::*;

   logic busy, done;
   rsp_type result;

   assign req.ready = !busy;

   ecc_seq u_seq (
      .clock(clock), .reset(reset), .start(req.valid && !busy), .req(req.data),
      .rsp_taken(rsp.ready), .busy(busy), .done(done), .rsp(result)
   );

   assign rsp.valid = done;
   assign rsp.data  = result;
endmodule

>>> rtl/ecc_checker.sv
// ----------------------------------------------------------------------------
// ecc_checker: port-level checks of the epoch calendar clock
// Handshake and result consistency properties.
// ----------------------------------------------------------------------------
module ecc_port_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input ecc_pkg::rsp_type rsp_data
);
   import ecc_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped");
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("ready with pending response");
   a_nok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.ok |-> rsp_data.elapsed == 32'd0)
      else $error("elapsed on invalid date");
   a_wd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.weekday != 3'd7) else $error("bad weekday");
endmodule

bind epoch_calendar_clock ecc_port_checker u_ecc_port_checker (
   .clock(clock), .reset(reset), .req_ready(req.ready), .rsp_valid(rsp.valid),
   .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);

>>> sim/ecc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecc_checker: response checker for the epoch calendar clock
// Watches both channels, keeps its own seconds counter, works out the
// response of every accepted request but a tick and compares responses in order.
// ----------------------------------------------------------------------------
module ecc_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  ecc_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  ecc_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending
);
   import ecc_pkg::*;

   localparam int unsigned MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

   bit [31:0] epoch_secs;
   rsp_type   rsp_queue [$];

   function automatic bit gregorian_leap(input int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic bit date_seconds(input req_type r, output bit [31:0] secs);
      bit [31:0] acc;
      acc = 0;
      secs = 0;
      if (r.year < YEAR_FIRST || r.year > YEAR_LAST || r.month < 1 || r.month > 12)
         return 0;
      for (int unsigned y = 32'(YEAR_FIRST); y < r.year; y++)
         acc += gregorian_leap(y) ? SECS_LEAP_YEAR : SECS_YEAR;
      for (int unsigned m = 0; m + 1 < r.month; m++) begin
         acc += MONTH_LEN[m] * SECS_DAY;
         if (m == 1 && gregorian_leap(32'(r.year)))
            acc += SECS_DAY;
      end
      acc += (32'(r.day) - 32'd1) * SECS_DAY;
      acc += 32'(r.hour) * SECS_HOUR + 32'(r.minute) * 32'd60 + 32'(r.second);
      secs = acc;
      return 1;
   endfunction

   function automatic rsp_type calendar_of(input bit [31:0] cnt);
      rsp_type     r;
      int unsigned days;
      int unsigned rem;
      int unsigned y;
      int unsigned m;
      int unsigned len;
      r = '0;
      days = cnt / SECS_DAY;
      rem = cnt % SECS_DAY;
      r.weekday = 3'((days + 4) % 7);
      y = 32'(YEAR_FIRST);
      m = 0;
      forever begin
         len = gregorian_leap(y) ? 366 : 365;
         if (days < len)
            break;
         days -= len;
         y++;
      end
      while (m < 11) begin
         len = MONTH_LEN[m];
         if (m == 1 && gregorian_leap(y))
            len = 29;
         if (days < len)
            break;
         days -= len;
         m++;
      end
      r.ok = 1'b1;
      r.out_year = 12'(y);
      r.out_month = 4'(m + 1);
      r.out_day = 5'(days + 1);
      r.out_hour = 5'(rem / SECS_HOUR);
      r.out_minute = 6'((rem % SECS_HOUR) / 60);
      r.out_second = 6'(rem % 60);
      return r;
   endfunction

   task automatic check_field(input string name, input bit [31:0] exp_v, input bit [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("field %s expected %0d actual %0d", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type   want;
      bit [31:0] secs;
      if (reset) begin
         epoch_secs = 0;
         fail_count = 0;
         rsp_queue.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (rsp_queue.size() == 0) begin
               $error("response transaction with no request waiting");
               fail_count++;
            end else begin
               want = rsp_queue.pop_front();
               check_field("ok", 32'(want.ok), 32'(rsp_data.ok));
               check_field("out_year", 32'(want.out_year), 32'(rsp_data.out_year));
               check_field("out_month", 32'(want.out_month), 32'(rsp_data.out_month));
               check_field("out_day", 32'(want.out_day), 32'(rsp_data.out_day));
               check_field("out_hour", 32'(want.out_hour), 32'(rsp_data.out_hour));
               check_field("out_minute", 32'(want.out_minute), 32'(rsp_data.out_minute));
               check_field("out_second", 32'(want.out_second), 32'(rsp_data.out_second));
               check_field("weekday", 32'(want.weekday), 32'(rsp_data.weekday));
               check_field("elapsed", want.elapsed, rsp_data.elapsed);
            end
         end
         if (req_valid && req_ready) begin
            want = '0;
            case (req_data.cmd)
               CMD_TICK: epoch_secs += 1;
               CMD_SET: begin
                  if (date_seconds(req_data, secs)) begin
                     epoch_secs = secs;
                     want.ok = 1'b1;
                  end
               end
               CMD_GET: want = calendar_of(epoch_secs);
               default: begin
                  if (date_seconds(req_data, secs)) begin
                     want.ok = 1'b1;
                     want.elapsed = epoch_secs - secs;
                  end
               end
            endcase
            if (req_data.cmd != CMD_TICK)
               rsp_queue.push_back(want);
         end
      end
      pending <= rsp_queue.size();
   end

endmodule

>>> sim/epoch_calendar_clock_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_calendar_clock_test: testbench of the epoch calendar clock
// Drives directed and random commands with random gaps and response stalls;
// a checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module epoch_calendar_clock_test;
   import ecc_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   steady = 1'b0;
   int   fail_count;
   int   pending;

   ecc_if #(.payload_type(req_type)) req_ch ();
   ecc_if #(.payload_type(rsp_type)) rsp_ch ();

   epoch_calendar_clock dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   ecc_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_ready  (req_ch.ready),
      .req_data   (req_ch.data),
      .rsp_valid  (rsp_ch.valid),
      .rsp_ready  (rsp_ch.ready),
      .rsp_data   (rsp_ch.data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_ch.ready <= steady || ($urandom_range(99) >= 27);
   end

   function automatic req_type make_req(input logic [1:0] cmd, input int y, input int mo,
                                        input int d, input int h, input int mi, input int s);
      req_type r;
      r.cmd = cmd;
      r.year = 12'(y);
      r.month = 4'(mo);
      r.day = 5'(d);
      r.hour = 5'(h);
      r.minute = 6'(mi);
      r.second = 6'(s);
      return r;
   endfunction

   task automatic send(input req_type r);
      while (!steady && $urandom_range(99) < 27) begin
         req_ch.valid <= 1'b0;
         req_ch.data <= req_type'(40'($urandom));
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= r;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   function automatic req_type random_date(input logic [1:0] cmd, input bit wide);
      req_type r;
      int      pick;
      r = req_type'(40'({$urandom, $urandom}));
      r.cmd = cmd;
      pick = $urandom_range(99);
      if (pick < 6) begin
         if ($urandom_range(1))
            r.month = 4'($urandom_range(1) ? 0 : $urandom_range(15, 13));
         else
            r.year = 12'($urandom_range(1) ? $urandom_range(1969, 0)
                                           : $urandom_range(4095, 2100));
      end else begin
         r.month = 4'($urandom_range(12, 1));
         r.year = 12'((wide || pick < 9) ? $urandom_range(YEAR_LAST, YEAR_FIRST)
                                        : $urandom_range(1973, YEAR_FIRST));
         // hold day zero of January 1970 back: it wraps to the top of the range
         if (r.year == YEAR_FIRST && r.month == 1 && r.day == 0)
            r.day = 1;
      end
      return r;
   endfunction

   initial begin
      req_type r;
      int      pick;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send(make_req(CMD_GET, 0, 0, 0, 0, 0, 0));
      send(make_req(CMD_TICK, 0, 0, 0, 0, 0, 0));
      send(make_req(CMD_GET, 0, 0, 0, 0, 0, 0));
      send(make_req(CMD_SET, 1970, 1, 0, 23, 59, 59));
      send(make_req(CMD_GET, 0, 0, 0, 0, 0, 0));
      send(make_req(CMD_TICK, 0, 0, 0, 0, 0, 0));
      send(make_req(CMD_GET, 0, 0, 0, 0, 0, 0));
      send(make_req(CMD_SET, 2099, 12, 31, 23, 59, 59));
      send(make_req(CMD_GET, 4095, 15, 31, 31, 63, 63));
      send(make_req(CMD_ELAPSED, 1970, 1, 1, 0, 0, 0));
      send(make_req(CMD_SET, 2000, 2, 29, 12, 34, 56));
      send(make_req(CMD_GET, 0, 0, 0, 0, 0, 0));
      send(make_req(CMD_ELAPSED, 2000, 3, 1, 0, 0, 0));
      send(make_req(CMD_SET, 1969, 6, 1, 0, 0, 0));
      send(make_req(CMD_SET, 2100, 1, 1, 0, 0, 0));
      send(make_req(CMD_SET, 1980, 0, 1, 0, 0, 0));
      send(make_req(CMD_SET, 1980, 13, 1, 0, 0, 0));
      send(make_req(CMD_ELAPSED, 4095, 15, 31, 31, 63, 63));
      send(make_req(CMD_SET, 1972, 12, 31, 31, 63, 63));
      send(make_req(CMD_GET, 0, 0, 0, 0, 0, 0));
      send(make_req(CMD_ELAPSED, 2099, 12, 31, 23, 59, 59));
      send(make_req(CMD_SET, 1970, 1, 1, 0, 0, 0));
      send(make_req(CMD_GET, 0, 0, 0, 0, 0, 0));

      for (int i = 0; i < 1100; i++) begin
         steady = (i >= 400 && i < 600);
         pick = $urandom_range(99);
         if (pick < 30) begin
            r = req_type'(40'({$urandom, $urandom}));
            r.cmd = CMD_TICK;
         end else if (pick < 55) begin
            r = random_date(CMD_SET, 1'b0);
         end else if (pick < 80) begin
            r = req_type'(40'({$urandom, $urandom}));
            r.cmd = CMD_GET;
         end else begin
            r = random_date(CMD_ELAPSED, 1'b1);
         end
         send(r);
      end
      steady = 1'b0;
      req_ch.valid <= 1'b0;
      @(posedge clock);
      @(posedge clock);
      wait (pending == 0);
      repeat (300) @(posedge clock);
      if (fail_count == 0)
         $display("PASS epoch_calendar_clock");
      else
         $display("FAIL epoch_calendar_clock");
      $finish;
   end

   initial begin
      #200_000_000;
      $display("FAIL epoch_calendar_clock");
      $finish;
   end

endmodule
